// File: design/volume_intensity_projection_defines.svh
// ----------------------------------------------------------------------------
// volume_intensity_projection_defines
// assertion macros shared by the projection block
// ----------------------------------------------------------------------------
`ifndef VOLUME_INTENSITY_PROJECTION_DEFINES_SVH
`define VOLUME_INTENSITY_PROJECTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vip_pkg.sv
// ----------------------------------------------------------------------------
// vip_pkg
// types and constants of the intensity projection block
// ----------------------------------------------------------------------------
`default_nettype none

package vip_pkg;

  localparam int unsigned VIP_MAX_WIDTH  = 512;
  localparam int unsigned VIP_MAX_HEIGHT = 512;
  localparam int unsigned VIP_MAX_DEPTH  = 1024;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned XSIZE_W    = 10;
  localparam int unsigned YSIZE_W    = 10;
  localparam int unsigned ZSIZE_W    = 11;
  localparam int unsigned VOXEL_W    = 8;

  localparam logic               MODE_RST   = 1'b0;
  localparam logic [XSIZE_W-1:0] XSIZE_RST  = XSIZE_W'(512);
  localparam logic [YSIZE_W-1:0] YSIZE_RST  = YSIZE_W'(512);
  localparam logic [ZSIZE_W-1:0] ZSIZE_RST  = ZSIZE_W'(1);

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_XSIZE = 2'd1,
    REG_YSIZE = 2'd2,
    REG_ZSIZE = 2'd3
  } cfg_reg_e;

  // per-voxel control from the sequencer to the store
  typedef struct packed {
    logic first;  // first slice, voxel is stored as is
    logic emit;   // last slice, a pixel goes out
    logic done;   // final pixel of the image
  } vip_ctl_t;

endpackage

`default_nettype wire

// File: design/vip_cfg.sv
// ----------------------------------------------------------------------------
// vip_cfg
// configuration registers and clamped last positions
// ----------------------------------------------------------------------------
`default_nettype none

module vip_cfg
  import vip_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = VIP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = VIP_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH  = VIP_MAX_DEPTH,
  localparam int unsigned XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned ZW = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       mode_o,
  output logic [XW-1:0]              x_last_o,
  output logic [YW-1:0]              y_last_o,
  output logic [ZW-1:0]              z_last_o
);

  logic               mode_q, mode_d;
  logic [XSIZE_W-1:0] xsize_q, xsize_d;
  logic [YSIZE_W-1:0] ysize_q, ysize_d;
  logic [ZSIZE_W-1:0] zsize_q, zsize_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d  = mode_q;
    xsize_d = xsize_q;
    ysize_d = ysize_q;
    zsize_d = zsize_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:  mode_d  = cfg_data_i[0];
        REG_XSIZE: xsize_d = cfg_data_i[XSIZE_W-1:0];
        REG_YSIZE: ysize_d = cfg_data_i[YSIZE_W-1:0];
        REG_ZSIZE: zsize_d = cfg_data_i[ZSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RST;
      xsize_q <= XSIZE_RST;
      ysize_q <= YSIZE_RST;
      zsize_q <= ZSIZE_RST;
    end else begin
      mode_q  <= mode_d;
      xsize_q <= xsize_d;
      ysize_q <= ysize_d;
      zsize_q <= zsize_d;
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    mode_o = mode_q;
    if (xsize_q == '0) begin
      x_last_o = '0;
    end else if (32'(xsize_q) > MAX_WIDTH) begin
      x_last_o = XW'(MAX_WIDTH - 1);
    end else begin
      x_last_o = XW'(32'(xsize_q) - 32'd1);
    end
    if (ysize_q == '0) begin
      y_last_o = '0;
    end else if (32'(ysize_q) > MAX_HEIGHT) begin
      y_last_o = YW'(MAX_HEIGHT - 1);
    end else begin
      y_last_o = YW'(32'(ysize_q) - 32'd1);
    end
    if (zsize_q == '0) begin
      z_last_o = '0;
    end else if (32'(zsize_q) > MAX_DEPTH) begin
      z_last_o = ZW'(MAX_DEPTH - 1);
    end else begin
      z_last_o = ZW'(32'(zsize_q) - 32'd1);
    end
  end

endmodule

`default_nettype wire

// File: design/vip_seq.sv
// ----------------------------------------------------------------------------
// vip_seq
// x/y/z position counters and column address generation
// ----------------------------------------------------------------------------
`default_nettype none

module vip_seq
  import vip_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = VIP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = VIP_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH  = VIP_MAX_DEPTH,
  localparam int unsigned XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned ZW = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1,
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [XW-1:0] x_last_i,
  input  wire logic [YW-1:0] y_last_i,
  input  wire logic [ZW-1:0] z_last_i,
  output logic [AW-1:0]      addr_o,
  output vip_ctl_t           ctl_o
);

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [ZW-1:0] z_q, z_d;
  logic [AW-1:0] row_q, row_d;
  logic          x_end, y_end, z_end;

  // a counter past a shrunken size counts as at its end
  assign x_end = (x_q >= x_last_i);
  assign y_end = (y_q >= y_last_i);
  assign z_end = (z_q >= z_last_i);

  assign addr_o      = row_q + AW'(x_q);
  assign ctl_o.first = (z_q == '0);
  assign ctl_o.emit  = z_end;
  assign ctl_o.done  = z_end && x_end && y_end;

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    row_d = row_q;
    if (step_i) begin
      if (!x_end) begin
        x_d = x_q + XW'(1);
      end else begin
        x_d = '0;
        if (!y_end) begin
          y_d   = y_q + YW'(1);
          row_d = row_q + AW'(MAX_WIDTH);
        end else begin
          y_d   = '0;
          row_d = '0;
          z_d   = z_end ? '0 : z_q + ZW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      row_q <= '0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// File: design/vip_store.sv
// ----------------------------------------------------------------------------
// vip_store
// column memory with read-modify-write stage and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "volume_intensity_projection_defines.svh"

module vip_store
  import vip_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = VIP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = VIP_MAX_HEIGHT,
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,
  input  wire logic [VOXEL_W-1:0] voxel_i,
  input  wire logic [AW-1:0]      addr_i,
  input  wire vip_ctl_t           ctl_i,
  input  wire logic               mode_i,
  output logic                    hold_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [VOXEL_W-1:0]      pixel_o,
  output logic                    done_o
);

  logic [VOXEL_W-1:0] mem_q [Depth];
  logic [VOXEL_W-1:0] rdata_q;

  logic               s1_valid_q, s1_valid_d;
  logic [VOXEL_W-1:0] s1_vox_q;
  logic [AW-1:0]      s1_addr_q;
  vip_ctl_t           s1_ctl_q;
  logic               fwd_q, fwd_d;
  logic [VOXEL_W-1:0] fwd_data_q;

  logic               out_valid_q, out_valid_d;
  logic [VOXEL_W-1:0] pixel_q;
  logic               done_q;

  logic [VOXEL_W-1:0] old_val, combined;
  logic               out_free, s1_adv;

  // write of the word ahead lands in the same edge as this read
  assign old_val = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    if (s1_ctl_q.first) begin
      combined = s1_vox_q;
    end else if (mode_i == MODE_MIN) begin
      combined = (s1_vox_q < old_val) ? s1_vox_q : old_val;
    end else begin
      combined = (s1_vox_q > old_val) ? s1_vox_q : old_val;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = s1_valid_q && (!s1_ctl_q.emit || out_free);
  assign hold_o   = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    fwd_d      = fwd_q;
    if (acc_i) begin
      s1_valid_d = 1'b1;
      fwd_d      = s1_adv && (s1_addr_q == addr_i);
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
      fwd_d      = 1'b0;
    end
    if (s1_adv && s1_ctl_q.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_vox_q   <= voxel_i;
      s1_addr_q  <= addr_i;
      s1_ctl_q   <= ctl_i;
      fwd_data_q <= combined;
    end
    if (s1_adv && s1_ctl_q.emit) begin
      pixel_q <= combined;
      done_q  <= s1_ctl_q.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_addr_q] <= combined;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign done_o      = done_q;

  `VIP_ASSERT_NOW(a_hold_needs_item, hold_o, s1_valid_q && s1_ctl_q.emit && !out_free,
    "input held without a blocked pixel")
  `VIP_ASSERT_NOW(a_fwd_needs_item, fwd_q, s1_valid_q, "forward flag without a word in flight")
  `VIP_ASSERT_NEXT(a_pixel_lands, s1_adv && s1_ctl_q.emit,
    out_valid_q && (pixel_q == $past(combined)), "combined pixel not registered")
  `VIP_ASSERT_NOW(a_no_accept_on_hold, hold_o, !acc_i, "word accepted while stage held")

endmodule

`default_nettype wire

// File: design/volume_intensity_projection.sv
// a last-slice voxel passes the store stage and then the output register to out_valid_o
// throughput: one voxel per cycle; input stalls only while a last-slice pixel waits
//   behind a stalled output register with another last-slice pixel in the store stage
// the column memory does one read and one write per cycle, forwarding covers back-to-back
//   hits on one column
// reset clears counters, config registers and valid flags, not memory or data registers
`default_nettype none

module volume_intensity_projection
  import vip_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = VIP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = VIP_MAX_HEIGHT,
  parameter int unsigned MAX_DEPTH  = VIP_MAX_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VOXEL_W-1:0]    voxel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [VOXEL_W-1:0]         pixel_o,
  output logic                       image_done_o
);

  localparam int unsigned XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ZW = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic          mode;
  logic [XW-1:0] x_last;
  logic [YW-1:0] y_last;
  logic [ZW-1:0] z_last;
  logic [AW-1:0] addr;
  vip_ctl_t      ctl;
  logic          hold;
  logic          acc;

  assign in_stall_o = hold;
  assign acc        = in_valid_i && !hold;

  vip_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mode_o      (mode),
    .x_last_o    (x_last),
    .y_last_o    (y_last),
    .z_last_o    (z_last)
  );

  vip_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (acc),
    .x_last_i (x_last),
    .y_last_i (y_last),
    .z_last_i (z_last),
    .addr_o   (addr),
    .ctl_o    (ctl)
  );

  vip_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .voxel_i     (voxel_i),
    .addr_i      (addr),
    .ctl_i       (ctl),
    .mode_i      (mode),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_o     (pixel_o),
    .done_o      (image_done_o)
  );

endmodule

`default_nettype wire
